// File: rtl/minstd_byte_stream_rng_core_assert.svh
// Assertion macros shared by the random byte stream RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef MINSTD_BYTE_STREAM_RNG_CORE_ASSERT_SVH
`define MINSTD_BYTE_STREAM_RNG_CORE_ASSERT_SVH

// Check a property on the rising clock edge, disabled while reset is high.
`define MSBRNG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clock edge, including during reset.
`define MSBRNG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/msbrng_pkg.sv
// Constants and helpers for the minimal standard random byte stream.
// No dependencies; imported by the multiply-reduce unit and the top level.
package msbrng_pkg;

   // Generator word and operand widths.
   localparam int WORD_W = 32;
   localparam int OPND_W = 31;
   localparam int FACT_W = 15;
   localparam int PROD_W = OPND_W + FACT_W;
   localparam int NSEC_W = 30;
   localparam int CNT_W  = 7;

   // Park-Miller modulus 2^31-1 and multiplier.
   localparam logic [OPND_W-1:0] PM_MODULUS = 31'h7FFF_FFFF;
   localparam logic [FACT_W-1:0] PM_FACTOR  = 15'd16807;

   // Most negative 32-bit value and its saturated magnitude.
   localparam logic [WORD_W-1:0] INT_MIN_WORD = 32'h8000_0000;
   localparam logic [WORD_W-1:0] INT_MAX_WORD = 32'h7FFF_FFFF;

endpackage

// File: rtl/msbrng_mulmod.sv
// Shared multiply-reduce unit: x -> 16807*x mod (2^31-1), zero mapped to modulus.
// Depends on msbrng_pkg. Start is registered into a stage flop, then into done with the result.
module msbrng_mulmod
   import msbrng_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [OPND_W-1:0] operand,
   output logic              done,
   output logic [OPND_W-1:0] result
);

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              stage_ff, stage_in;
   logic              done_ff, done_in;
   logic [OPND_W-1:0] res_ff, res_in;
   logic [OPND_W:0]   fold_sum;
   logic [OPND_W:0]   fold_sub;
   logic [OPND_W-1:0] fold_mod;

   // First cycle: the product of operand and multiplier.
   assign prod_in  = PROD_W'(operand) * PROD_W'(PM_FACTOR);
   assign stage_in = start;

   // Second cycle: fold the high part onto the low part, since 2^31 = 1 modulo
   // the modulus; the sum stays below twice the modulus, so one subtract ends it.
   always_comb begin
      fold_sum = {1'b0, prod_ff[OPND_W-1:0]} + (OPND_W+1)'(prod_ff[PROD_W-1:OPND_W]);
      fold_sub = fold_sum - {1'b0, PM_MODULUS};
      if (fold_sum >= {1'b0, PM_MODULUS}) begin
         fold_mod = fold_sub[OPND_W-1:0];
      end else begin
         fold_mod = fold_sum[OPND_W-1:0];
      end
      // A zero residue is replaced by the modulus itself.
      if (fold_mod == '0) begin
         res_in = PM_MODULUS;
      end else begin
         res_in = fold_mod;
      end
      done_in = stage_ff;
   end

   // Control flops are reset; data flops are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (stage_ff) begin
         res_ff <= res_in;
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// File: rtl/minstd_byte_stream_rng_core.sv
// Random byte stream core: a read of N bytes first mixes the latched timestamp into
// the seed, then per generator step runs the shared multiply-reduce unit and emits up
// to 4 bytes of the word, stalling while the output waits for rsp_ready.
// An interrupt event is taken in idle and leaves the block ready for the next request.
// The block takes no new request until a read has loaded its last byte for output.
// Synchronous active-high reset: seed is 1, latched timestamp is 0, output empty.
module minstd_byte_stream_rng_core
   import msbrng_pkg::*;
#(
   parameter int MAX_BYTES = 64
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic              req_sample_enable,
   input  logic [NSEC_W-1:0] req_event_nsec,
   input  logic [CNT_W-1:0]  req_byte_count,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_data_byte,
   output logic              rsp_last_byte
);

`include "minstd_byte_stream_rng_core_assert.svh"

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MIX  = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [WORD_W-1:0] seed_ff, seed_in;
   logic [NSEC_W-1:0] nsec_ff, nsec_in;
   logic [WORD_W-1:0] x_ff, x_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [1:0]        bidx_ff, bidx_in;
   logic              tail_ff, tail_in;
   logic              start_ff, start_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_fire;
   logic [CNT_W-1:0]  count_clamp;
   logic [WORD_W-1:0] mix_sum;
   logic [WORD_W-1:0] mix_abs;
   logic              out_free;
   logic [7:0]        sel_byte;
   logic [WORD_W-1:0] x_shift;
   logic              mm_done;
   logic [OPND_W-1:0] mm_result;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Requests above the limit are clamped to it.
   assign count_clamp = (int'(req_byte_count) > MAX_BYTES) ? CNT_W'(MAX_BYTES) : req_byte_count;

   // Mix the timestamp into the seed and take a saturating absolute value.
   always_comb begin
      mix_sum = seed_ff + WORD_W'(nsec_ff);
      if (mix_sum == INT_MIN_WORD) begin
         mix_abs = INT_MAX_WORD;
      end else if (mix_sum[WORD_W-1]) begin
         mix_abs = '0 - mix_sum;
      end else begin
         mix_abs = mix_sum;
      end
   end

   // Full words go out as bytes 3, 1, 2, 0; a tail always takes the top byte.
   always_comb begin
      x_shift = {x_ff[WORD_W-9:0], 8'h00};
      if (tail_ff) begin
         sel_byte = x_ff[31:24];
      end else begin
         case (bidx_ff)
            2'd0:    sel_byte = x_ff[31:24];
            2'd1:    sel_byte = x_ff[15:8];
            2'd2:    sel_byte = x_ff[23:16];
            default: sel_byte = x_ff[7:0];
         endcase
      end
   end

   // Sequencer over the shared multiply-reduce unit.
   always_comb begin
      state_in     = state_ff;
      seed_in      = seed_ff;
      nsec_in      = nsec_ff;
      x_in         = x_ff;
      rem_in       = rem_ff;
      bidx_in      = bidx_ff;
      tail_in      = tail_ff;
      start_in     = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_op) begin
                  rem_in   = count_clamp;
                  state_in = ST_MIX;
               end else if (req_sample_enable) begin
                  nsec_in = req_event_nsec;
               end
            end
         end
         ST_MIX: begin
            x_in = mix_abs;
            if (rem_ff == '0) begin
               seed_in  = mix_abs;
               state_in = ST_IDLE;
            end else begin
               start_in = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mm_done) begin
               x_in     = WORD_W'(mm_result);
               tail_in  = (rem_ff < CNT_W'(4));
               bidx_in  = 2'd0;
               state_in = ST_EMIT;
            end
         end
         default: begin
            if (out_free) begin
               rsp_data_in  = sel_byte;
               rsp_last_in  = (rem_ff == CNT_W'(1));
               rsp_valid_in = 1'b1;
               rem_in       = rem_ff - CNT_W'(1);
               bidx_in      = bidx_ff + 2'd1;
               if (tail_ff) begin
                  x_in = x_shift;
               end
               if (rem_ff == CNT_W'(1)) begin
                  seed_in  = tail_ff ? x_shift : x_ff;
                  state_in = ST_IDLE;
               end else if (bidx_ff == 2'd3) begin
                  start_in = 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
      endcase
   end

   // Control state and generator state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= 32'd1;
         nsec_ff      <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rem_ff       <= '0;
         bidx_ff      <= '0;
         tail_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         nsec_ff      <= nsec_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         rem_ff       <= rem_in;
         bidx_ff      <= bidx_in;
         tail_ff      <= tail_in;
      end
   end

   // Working word and output payload.
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   msbrng_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .operand (x_ff[OPND_W-1:0]),
      .done    (mm_done),
      .result  (mm_result)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_byte = rsp_data_ff;
   assign rsp_last_byte = rsp_last_ff;

   // Generator steps are started only while the sequencer waits for them.
   `MSBRNG_ASSERT(a_start_in_mul, clock, reset, start_ff |-> state_ff == ST_MUL, "start outside wait")
   `MSBRNG_ASSERT(a_done_in_mul, clock, reset, mm_done |-> state_ff == ST_MUL, "unexpected step done")
   `MSBRNG_ASSERT(a_step_range, clock, reset, mm_done |-> (mm_result != '0 && mm_result <= PM_MODULUS), "step out of range")
   `MSBRNG_ASSERT(a_emit_count, clock, reset, state_ff == ST_EMIT |-> rem_ff != '0, "emit with no bytes left")

endmodule
